// ----- design/bitmap_frame_allocator_macros.svh -----
// Assertion macros for the bitmap frame allocator.
// No dependencies; included by bitmap_frame_allocator, which carries the assertions.
`ifndef BITMAP_FRAME_ALLOCATOR_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/bfa_pkg.sv -----
// Shared types, constants and helpers of the bitmap frame allocator.
// No dependencies; imported by every module of the block.
package bfa_pkg;

  localparam int unsigned MAX_FRAMES  = 4096;
  localparam int unsigned WORD_BITS   = 64;
  localparam int unsigned WORD_COUNT  = MAX_FRAMES / WORD_BITS;
  localparam int unsigned WIDX_W      = $clog2(WORD_COUNT);
  localparam int unsigned BIT_W       = $clog2(WORD_BITS);
  localparam int unsigned FIDX_W      = WIDX_W + BIT_W;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned ADDR_W      = 24;
  localparam int unsigned CNT_W       = 13;
  localparam int unsigned FUNC_W      = 2;
  localparam int unsigned STAT_W      = 2;
  localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_FRAMES);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_FREE    = 2'd1,
    FUNC_RESERVE = 2'd2
  } func_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 2'd0,
    STAT_NO_FRAME = 2'd1,
    STAT_RANGE    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MODIFY,
    S_SCAN,
    S_RESULT
  } state_e;

  typedef logic [WORD_BITS-1:0] word_t;

  // Request to the bitmap memory for one cycle.
  typedef struct packed {
    logic              rd_en;
    logic [WIDX_W-1:0] rd_addr;
    logic              wr_en;
    logic [WIDX_W-1:0] wr_addr;
    word_t             wr_data;
  } mem_req_t;

  // Word contents after reset: only frame 0 is marked used.
  function automatic word_t reset_word(input logic [WIDX_W-1:0] widx);
    word_t w;
    w = '0;
    if (widx == '0) w[0] = 1'b1;
    return w;
  endfunction

endpackage

// ----- design/bfa_bitmap_mem.sv -----
// Used-bit memory: one word per WORD_BITS frames, synchronous read.
// Depends on bfa_pkg; unwritten words read back as their reset value.
module bfa_bitmap_mem import bfa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mem_req_t req_i,
  output word_t    rdata_o
);

  word_t                   mem_q [WORD_COUNT];
  logic [WORD_COUNT-1:0]   written_q;
  word_t                   rdata_q;
  logic                    rd_written_q;
  logic [WIDX_W-1:0]       rd_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
    end else if (req_i.wr_en) begin
      written_q[req_i.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rdata_q      <= mem_q[req_i.rd_addr];
      rd_written_q <= written_q[req_i.rd_addr];
      rd_addr_q    <= req_i.rd_addr;
    end
  end

  assign rdata_o = rd_written_q ? rdata_q : reset_word(rd_addr_q);

endmodule

// ----- design/bfa_word_scan.sv -----
// Per-word search: masks frames beyond the count and finds the lowest free bit.
// Depends on bfa_pkg.
module bfa_word_scan import bfa_pkg::*; (
  input  word_t              word_i,
  input  logic [WIDX_W-1:0]  widx_i,
  input  logic [CNT_W-1:0]   count_i,
  output logic               found_o,
  output logic [BIT_W-1:0]   bit_o,
  output logic               last_o
);

  localparam int unsigned WHI_W = CNT_W - BIT_W;

  logic [WHI_W-1:0] widx_ext;
  logic [WHI_W-1:0] widx_next;
  word_t            in_range;
  word_t            free;
  word_t            lowest;

  assign widx_ext  = WHI_W'(widx_i);
  assign widx_next = widx_ext + WHI_W'(1);

  always_comb begin
    if (widx_ext < count_i[CNT_W-1:BIT_W]) begin
      in_range = '1;
    end else if (widx_ext == count_i[CNT_W-1:BIT_W]) begin
      in_range = (word_t'(1) << count_i[BIT_W-1:0]) - word_t'(1);
    end else begin
      in_range = '0;
    end
  end

  assign free    = ~word_i & in_range;
  assign lowest  = free & (~free + word_t'(1));
  assign found_o = |free;

  // Encode the isolated lowest free bit.
  always_comb begin
    bit_o = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      bit_o = bit_o | (lowest[b] ? BIT_W'(b) : '0);
    end
  end

  // No word past this one holds a managed frame.
  assign last_o = {widx_next, {BIT_W{1'b0}}} >= count_i;

endmodule

// ----- design/bitmap_frame_allocator.sv -----
// Bitmap page-frame allocator: one used bit per 4 KiB frame.
// Slave stream beats carry an operation; the master stream returns one result
// beat per input beat, in order.
//   s_axis_tuser: func (0 allocate, 1 free, 2 reserve); s_axis_tdata: byte
//   address of the frame to free or reserve.
//   m_axis_tdata: allocated byte address (zero otherwise); m_axis_tuser: status
//   (0 ok, 1 no free frame, 2 address out of range).
//   cfg channel: writes frame_count; take it only while no beat is in flight.
// The bitmap lives in a 64 x 64-bit synchronous RAM. Allocate reads one word
// per cycle from word 0 and picks the lowest free bit of the first word that
// has one. Free and reserve do one read-modify-write; out-of-range and unknown
// operations do not touch the RAM. One beat is worked on at a time; the next
// beat is taken once the previous one has reached the output register, even
// if the receiver has not yet taken it.
// Reset marks every frame free except frame 0 at once (per-word written bits,
// no clearing pass) and sets frame_count to 4096.
// A stalled receiver holds the result in the output register; a finished
// beat waits in the result state until that register frees up.
`include "bitmap_frame_allocator_macros.svh"

module bitmap_frame_allocator import bfa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Input stream
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [ADDR_W-1:0] s_axis_tdata,   // [23:0] frame_address
  input  logic [FUNC_W-1:0] s_axis_tuser,   // [1:0] func
  // Result stream
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [ADDR_W-1:0] m_axis_tdata,   // [23:0] result_address
  output logic [STAT_W-1:0] m_axis_tuser,   // [1:0] status
  // Configuration write channel
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [CNT_W-1:0]  cfg_data_i      // frame_count
);

  state_e              state_q, state_d;
  logic [CNT_W-1:0]    frame_count_q;
  logic [CNT_W-1:0]    count;
  logic [WIDX_W-1:0]   widx_q, widx_d;
  logic [BIT_W-1:0]    bit_q, bit_d;
  logic                set_q, set_d;
  logic [ADDR_W-1:0]   res_addr_q, res_addr_d;
  status_e             res_stat_q, res_stat_d;
  logic                out_valid_q;
  logic [ADDR_W-1:0]   out_addr_q;
  status_e             out_stat_q;

  mem_req_t            mem_req;
  word_t               rdata;
  logic                scan_found;
  logic [BIT_W-1:0]    scan_bit;
  logic                scan_last;

  logic                in_beat;
  logic [FIDX_W-1:0]   in_fidx;
  logic                out_load;
  word_t               bit_mask;

  // Configuration: always ready, the block is idle by contract.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_count_q <= COUNT_RESET;
    end else if (cfg_valid_i) begin
      frame_count_q <= cfg_data_i;
    end
  end

  // Saturate the managed count at the bitmap size.
  assign count = (frame_count_q > COUNT_RESET) ? COUNT_RESET : frame_count_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign in_fidx       = s_axis_tdata[FRAME_SHIFT +: FIDX_W];
  assign out_load      = (state_q == S_RESULT) && (!out_valid_q || m_axis_tready);
  assign bit_mask      = word_t'(1) << bit_q;

  bfa_bitmap_mem u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  bfa_word_scan u_scan (
    .word_i  (rdata),
    .widx_i  (widx_q),
    .count_i (count),
    .found_o (scan_found),
    .bit_o   (scan_bit),
    .last_o  (scan_last)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          case (s_axis_tuser)
            FUNC_ALLOC: state_d = (count == '0) ? S_RESULT : S_SCAN;
            FUNC_FREE, FUNC_RESERVE: begin
              state_d = (CNT_W'(in_fidx) >= count) ? S_RESULT : S_MODIFY;
            end
            default: state_d = S_RESULT;
          endcase
        end
      end
      S_MODIFY: state_d = S_RESULT;
      S_SCAN: begin
        if (scan_found || scan_last) state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory requests.
  always_comb begin
    mem_req    = '0;
    widx_d     = widx_q;
    bit_d      = bit_q;
    set_d      = set_q;
    res_addr_d = res_addr_q;
    res_stat_d = res_stat_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          res_addr_d = '0;
          res_stat_d = STAT_OK;
          case (s_axis_tuser)
            FUNC_ALLOC: begin
              widx_d = '0;
              if (count == '0) begin
                res_stat_d = STAT_NO_FRAME;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = '0;
              end
            end
            FUNC_FREE, FUNC_RESERVE: begin
              widx_d = in_fidx[FIDX_W-1:BIT_W];
              bit_d  = in_fidx[BIT_W-1:0];
              set_d  = (s_axis_tuser == FUNC_RESERVE);
              if (CNT_W'(in_fidx) >= count) begin
                res_stat_d = STAT_RANGE;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = in_fidx[FIDX_W-1:BIT_W];
              end
            end
            default: ;
          endcase
        end
      end
      S_MODIFY: begin
        // Write back the word with the one bit set or cleared.
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = widx_q;
        mem_req.wr_data = set_q ? (rdata | bit_mask) : (rdata & ~bit_mask);
      end
      S_SCAN: begin
        if (scan_found) begin
          mem_req.wr_en   = 1'b1;
          mem_req.wr_addr = widx_q;
          mem_req.wr_data = rdata | (word_t'(1) << scan_bit);
          res_addr_d      = {widx_q, scan_bit, {FRAME_SHIFT{1'b0}}};
          res_stat_d      = STAT_OK;
        end else if (scan_last) begin
          res_addr_d = '0;
          res_stat_d = STAT_NO_FRAME;
        end else begin
          // Advance to the next word.
          widx_d          = widx_q + WIDX_W'(1);
          mem_req.rd_en   = 1'b1;
          mem_req.rd_addr = widx_q + WIDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    widx_q     <= widx_d;
    bit_q      <= bit_d;
    set_q      <= set_d;
    res_addr_q <= res_addr_d;
    res_stat_q <= res_stat_d;
    if (out_load) begin
      out_addr_q <= res_addr_q;
      out_stat_q <= res_stat_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_addr_q;
  assign m_axis_tuser  = out_stat_q;

  // Read-modify-write never reads and writes the RAM in one cycle.
  `BFA_ASSERT_IMPL(a_no_rd_wr_overlap, clk_i, rst_ni, mem_req.wr_en, !mem_req.rd_en,
    "bitmap read and write issued in the same cycle")
  // Read data is consumed only in the cycle after a read was issued.
  `BFA_ASSERT_IMPL(a_rdata_fresh, clk_i, rst_ni,
    (state_q == S_MODIFY) || (state_q == S_SCAN), $past(mem_req.rd_en),
    "bitmap word used without a preceding read")
  // A result loaded into the output register is shown next cycle.
  `BFA_ASSERT_NEXT(a_result_shown, clk_i, rst_ni, out_load, m_axis_tvalid,
    "result beat lost on load")
  // A new result beat only comes from the result state.
  `BFA_ASSERT_IMPL(a_result_source, clk_i, rst_ni, $rose(m_axis_tvalid),
    $past(state_q == S_RESULT), "result beat appeared outside the result state")

endmodule

// ----- bench/tb_bitmap_frame_allocator.sv -----
// Self-checking testbench for the bitmap frame allocator: stream driver, result
// monitor, in-bench bitmap predictor. Depends on bfa_pkg and the allocator RTL.
module tb_bitmap_frame_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import bfa_pkg::*;

  // func value that has no operation behind it; the block must answer it anyway
  localparam logic [FUNC_W-1:0] FUNC_UNKNOWN = 2'd3;

  localparam int unsigned IDLE_PCT      = 29;   // chance of a bubble per cycle, each side
  localparam int unsigned SETTLE_CYCLES = 4;    // quiet cycles before a frame_count write
  localparam int unsigned TAIL_CYCLES   = 80;   // longer than the worst scan
  localparam int unsigned STALL_AT      = 200;  // results seen before the long hold-off
  localparam int unsigned STALL_CYCLES  = 400;
  localparam int unsigned PHASE_ITEMS   = 100;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
  } frame_op_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_e           status;
  } frame_reply_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [ADDR_W-1:0] s_axis_tdata  = '0;   // [23:0] frame_address
  logic [FUNC_W-1:0] s_axis_tuser  = '0;   // [1:0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [ADDR_W-1:0] m_axis_tdata;         // [23:0] result_address
  logic [STAT_W-1:0] m_axis_tuser;         // [1:0] status
  logic              cfg_valid_i   = 1'b0;
  logic              cfg_ready_o;
  logic [CNT_W-1:0]  cfg_data_i    = '0;   // frame_count

  bitmap_frame_allocator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  // Predictor state: our own copy of the used bitmap and the frame_count register.
  logic [MAX_FRAMES-1:0] frames_used = MAX_FRAMES'(1);  // frame 0 held after reset
  logic [CNT_W-1:0]      frame_limit = COUNT_RESET;

  frame_op_t    pending_ops[$];      // beats still to be offered on the input stream
  frame_reply_t awaited_results[$];  // predicted results, oldest first

  bit calm_phase = 1'b0;             // suppress random bubbles on both sides

  int unsigned errors       = 0;
  int unsigned ops_accepted = 0;
  int unsigned replies_seen = 0;
  int unsigned n_granted    = 0;
  int unsigned n_exhausted  = 0;
  int unsigned n_range      = 0;
  int unsigned n_unknown    = 0;
  int unsigned n_cfg_writes = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run.
  initial begin
    #5ms;
    $display("  timeout at %0t: %0d beats accepted, %0d results seen, %0d awaited",
             $time, ops_accepted, replies_seen, awaited_results.size());
    $display("CHECKS FAILED");
    $finish;
  end

  // Work out the result of one accepted beat and update the bitmap copy.
  task automatic predict_allocation(input logic [FUNC_W-1:0] func,
                                    input logic [ADDR_W-1:0] addr);
    int unsigned  managed;
    int unsigned  fidx;
    int unsigned  i;
    bit           found;
    frame_reply_t r;
    // frame_count saturates at the bitmap size
    managed  = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
    fidx     = addr >> FRAME_SHIFT;
    r.addr   = '0;
    r.status = STAT_OK;
    found    = 1'b0;
    case (func)
      FUNC_ALLOC: begin
        // first free frame from 0 up wins
        for (i = 0; i < managed && !found; i++) begin
          if (!frames_used[i]) begin
            frames_used[i] = 1'b1;
            r.addr         = ADDR_W'(i << FRAME_SHIFT);
            found          = 1'b1;
          end
        end
        if (found) begin
          n_granted++;
        end else begin
          r.status = STAT_NO_FRAME;
          n_exhausted++;
        end
      end
      FUNC_FREE, FUNC_RESERVE: begin
        // out of range leaves the bitmap alone; a repeated free or reserve just sticks
        if (fidx >= managed) begin
          r.status = STAT_RANGE;
          n_range++;
        end else begin
          frames_used[fidx] = (func == FUNC_RESERVE);
        end
      end
      default: begin
        n_unknown++;
      end
    endcase
    awaited_results.push_back(r);
  endtask

  // Input driver: predict on each accepted beat, then offer the next one or a bubble.
  always @(posedge clk_i or negedge rst_ni) begin : drive_ops
    frame_op_t op;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_allocation(s_axis_tuser, s_axis_tdata);
        ops_accepted++;
      end
      // hold the current beat until it is taken
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() > 0 && (calm_phase || $urandom_range(99) >= IDLE_PCT)) begin
          op = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= op.addr;
          s_axis_tuser  <= op.func;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Compare one result beat against the oldest prediction.
  task automatic check_reply(input logic [ADDR_W-1:0] addr, input logic [STAT_W-1:0] status);
    frame_reply_t r;
    replies_seen++;
    if (awaited_results.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing expected: addr 0x%06h status %0d",
               $time, addr, status);
    end else begin
      r = awaited_results.pop_front();
      if (addr !== r.addr) begin
        errors++;
        $display("%0t: result_address mismatch: expected 0x%06h, actual 0x%06h",
                 $time, r.addr, addr);
      end
      if (status !== r.status) begin
        errors++;
        $display("%0t: status mismatch: expected %0d, actual %0d", $time, r.status, status);
      end
    end
  endtask

  // Long receiver hold-off, counted in cycles: start once mid-run and hold
  // long enough that the input side has to stall.
  int unsigned stall_left = 0;
  bit          stall_done = 1'b0;

  always @(posedge clk_i) begin : hold_off
    if (!stall_done && replies_seen >= STALL_AT) begin
      stall_done <= 1'b1;
      stall_left <= STALL_CYCLES;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // Result monitor: check each taken beat, drive tready with bubbles and the hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : watch_results
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        check_reply(m_axis_tdata, m_axis_tuser);
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm_phase || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic push_op(input logic [FUNC_W-1:0] func, input logic [ADDR_W-1:0] addr);
    frame_op_t op;
    op.func = func;
    op.addr = addr;
    pending_ops.push_back(op);
  endtask

  // Block until every queued beat is in and every predicted result has come back.
  // Look on the falling edge, once the driver's updates have settled.
  task automatic wait_drained();
    while (pending_ops.size() != 0 || s_axis_tvalid || awaited_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write frame_count only once the block has gone idle.
  task automatic set_frame_count(input logic [CNT_W-1:0] value);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    cfg_valid_i <= 1'b0;
    frame_limit  = value;
    n_cfg_writes++;
    @(negedge clk_i);
  endtask

  // One random phase: mostly allocate / free / reserve inside the managed range,
  // plus out-of-range requests, unknown func and raw noise.
  task automatic queue_random_phase(input int unsigned n, input int unsigned alloc_pct);
    int unsigned       managed;
    int unsigned       k;
    int unsigned       roll;
    logic [FIDX_W-1:0] fidx;
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] addr;
    managed = (frame_limit > MAX_FRAMES) ? MAX_FRAMES : frame_limit;
    for (k = 0; k < n; k++) begin
      addr = ADDR_W'($urandom);
      func = $urandom_range(1) ? FUNC_FREE : FUNC_RESERVE;
      if ($urandom_range(99) < alloc_pct) begin
        func = FUNC_ALLOC;
      end else begin
        roll = $urandom_range(99);
        if (roll < 75) begin
          // in range; frees and reserves land on frames that allocations touch
          if (managed > 0) begin
            fidx = FIDX_W'($urandom_range(managed - 1));
            addr = ADDR_W'((fidx << FRAME_SHIFT) | $urandom_range(4095));
          end
          func = (roll < 45) ? FUNC_FREE : FUNC_RESERVE;
        end else if (roll < 87) begin
          if (managed < MAX_FRAMES) begin
            fidx = FIDX_W'($urandom_range(MAX_FRAMES - 1, managed));
            addr = ADDR_W'((fidx << FRAME_SHIFT) | $urandom_range(4095));
          end
        end else if (roll < 93) begin
          func = FUNC_UNKNOWN;
        end else begin
          func = FUNC_W'($urandom);
        end
      end
      push_op(func, addr);
    end
  endtask

  int unsigned      ph;
  logic [CNT_W-1:0] phase_count [5];
  int unsigned      phase_alloc [5];

  initial begin
    phase_count = '{13'd64, 13'd3, 13'd130, 13'd4096, 13'd0};
    phase_alloc = '{60, 50, 45, 40, 50};
    phase_count[4] = CNT_W'($urandom_range(200, 1));

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part at the reset frame_count of 4096.
    push_op(FUNC_ALLOC,   24'h000000);   // frame 0 held from reset: expect frame 1
    push_op(FUNC_FREE,    24'h000000);   // release frame 0
    push_op(FUNC_ALLOC,   24'hFFFFFF);   // address ignored: expect frame 0
    push_op(FUNC_RESERVE, 24'hFFFFFF);   // top frame
    push_op(FUNC_FREE,    24'hFFF123);   // same frame, offset bits ignored
    push_op(FUNC_FREE,    24'h005000);   // free of a free frame stays free
    push_op(FUNC_RESERVE, 24'h002ABC);
    push_op(FUNC_RESERVE, 24'h002000);   // reserve of a used frame stays used
    push_op(FUNC_ALLOC,   24'h000000);   // skips frame 2: expect frame 3
    push_op(FUNC_UNKNOWN, 24'hFFFFFF);
    push_op(FUNC_UNKNOWN, 24'h000000);

    // Smallest nonzero count: only frame 0 is managed.
    set_frame_count(13'd1);
    push_op(FUNC_ALLOC,   24'h000000);   // frame 0 in use: no free frame
    push_op(FUNC_FREE,    24'h000FFF);
    push_op(FUNC_ALLOC,   24'h000000);
    push_op(FUNC_RESERVE, 24'h001000);   // first frame past the count
    push_op(FUNC_FREE,    24'hFFFFFF);

    // Zero count: nothing is managed at all.
    set_frame_count(13'd0);
    push_op(FUNC_ALLOC,   24'h000000);
    push_op(FUNC_FREE,    24'h000000);
    push_op(FUNC_RESERVE, 24'h000000);

    // Counts above the bitmap size saturate.
    set_frame_count(13'h1FFF);
    push_op(FUNC_ALLOC,   24'h000000);
    push_op(FUNC_RESERVE, 24'hFFFFFF);
    set_frame_count(13'd4097);
    push_op(FUNC_FREE,    24'hFFFFFF);
    push_op(FUNC_ALLOC,   24'hABCDEF);

    // Random part, one frame_count per phase; the third phase runs without bubbles.
    for (ph = 0; ph < 5; ph++) begin
      set_frame_count(phase_count[ph]);
      calm_phase = (ph == 2);
      queue_random_phase(PHASE_ITEMS, phase_alloc[ph]);
    end

    wait_drained();
    calm_phase = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (awaited_results.size() != 0) begin
      errors++;
      $display("%0t: %0d predicted results never arrived", $time, awaited_results.size());
    end

    $display("Covered %0d beats over %0d frame_count writes: %0d frames granted, %0d no-frame,",
             ops_accepted, n_cfg_writes, n_granted, n_exhausted);
    $display("  %0d out-of-range and %0d unknown-func beats; %0d results checked.",
             n_range, n_unknown, replies_seen);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/bfa_pkg.sv
design/bfa_bitmap_mem.sv
design/bfa_word_scan.sv
design/bitmap_frame_allocator.sv
bench/tb_bitmap_frame_allocator.sv
